// ===== rtl/rsm_pkg.sv =====
// Shared types, constants and helpers for the rightmost substring match core.
`timescale 1ns / 1ps

package rsm_pkg;

  localparam int PAT_MAX   = 8;
  localparam int MAX_LEN   = 65536;

  localparam int CHAR_W    = 8;
  localparam int LEN_W     = 4;
  localparam int PBYTES_W  = 64;
  localparam int PSEL_W    = 3;
  localparam int MATCH_W   = 17;
  localparam int POS_W     = $clog2(MAX_LEN + 1);
  localparam int CNT_W     = POS_W + 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 1'b1;

  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LEN);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(MAX_LEN - 1);

  // Control handed to each window cell.
  typedef struct packed {
    logic              shift;
    logic              active;
    logic [CHAR_W-1:0] pat;
  } cell_ctl_t;

  function automatic logic [CHAR_W-1:0] pat_byte(input logic [PBYTES_W-1:0] bytes,
                                                 input logic [PSEL_W-1:0]   sel);
    pat_byte = bytes[sel*CHAR_W +: CHAR_W];
  endfunction

endpackage

// ===== rtl/rsm_cell.sv =====
// One window cell: compares its incoming character and passes it to the next cell.
`timescale 1ns / 1ps

module rsm_cell (
  input  logic                      clk,
  input  rsm_pkg::cell_ctl_t        ctl,
  input  logic [rsm_pkg::CHAR_W-1:0] char_in,
  input  logic                      hit_in,
  output logic [rsm_pkg::CHAR_W-1:0] char_out,
  output logic                      hit_out
);
  import rsm_pkg::*;

  logic [CHAR_W-1:0] char_r;

  // Cells past the pattern length do not take part in the compare.
  assign hit_out  = hit_in & (~ctl.active | (char_in == ctl.pat));
  assign char_out = char_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      char_r <= char_in;
    end
  end

endmodule

// ===== rtl/rightmost_substring_match_core.sv =====
// Rightmost substring match core: window cell chain, position tracking and result register.
// Result timing: out_valid rises in the cycle after its end request is accepted.
// Throughput: one request per cycle; the window compare is done by the cell chain in the
// accepting cycle, and the single output register stalls input only while a result waits and out_ready is low.
// Reset (synchronous, active low): pattern length and bytes zero, position zero, no match
// kept, overflow clear, output empty.
`timescale 1ns / 1ps

module rightmost_substring_match_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rsm_pkg::CHAR_W-1:0]       in_character,
  input  logic                             in_end_req,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [rsm_pkg::MATCH_W-1:0] out_match_index,
  output logic                             out_overflow,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rsm_pkg::PBYTES_W-1:0]     cfg_data
);
  import rsm_pkg::*;

  logic [LEN_W-1:0]    pat_len_r;
  logic [PBYTES_W-1:0] pat_bytes_r;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [MATCH_W-1:0]  match_r, match_nxt;
  logic                ovf_r, ovf_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [MATCH_W-1:0]  out_match_r;
  logic                out_ovf_r;

  logic                accept;
  logic                take_char;
  logic                saturated;
  logic [POS_W-1:0]    cur_pos;
  logic [LEN_W-1:0]    len_c;
  logic                enough;
  logic [POS_W-1:0]    start_pos;

  cell_ctl_t         ctl  [PAT_MAX];
  logic [CHAR_W-1:0] win  [PAT_MAX];
  logic              hit  [PAT_MAX+1];

  assign cfg_ready = 1'b1;
  assign in_ready  = ~out_valid_r | out_ready;
  assign accept    = in_valid & in_ready;
  assign take_char = accept & ~in_end_req;

  assign len_c = (pat_len_r > LEN_W'(PAT_MAX)) ? LEN_W'(PAT_MAX) : pat_len_r;

  // Hold the position at the last index once the string runs past the limit.
  assign saturated = (pos_r == POS_LIMIT);
  assign cur_pos   = saturated ? POS_LAST : pos_r;
  assign enough    = (len_c != '0) && ((CNT_W'(cur_pos) + CNT_W'(1)) >= CNT_W'(len_c));
  assign start_pos = cur_pos - (POS_W'(len_c) - POS_W'(1));

  assign win[0] = in_character;
  assign hit[0] = enough;

  for (genvar j = 0; j < PAT_MAX; j++) begin : g_cell
    logic [LEN_W-1:0] sel_full;
    assign sel_full      = len_c - LEN_W'(1) - LEN_W'(j);
    assign ctl[j].shift  = take_char;
    assign ctl[j].active = (LEN_W'(j) < len_c);
    assign ctl[j].pat    = pat_byte(pat_bytes_r, sel_full[PSEL_W-1:0]);

    if (j < PAT_MAX - 1) begin : g_mid
      rsm_cell u_cell (
        .clk      (clk),
        .ctl      (ctl[j]),
        .char_in  (win[j]),
        .hit_in   (hit[j]),
        .char_out (win[j+1]),
        .hit_out  (hit[j+1])
      );
    end else begin : g_last
      rsm_cell u_cell (
        .clk      (clk),
        .ctl      (ctl[j]),
        .char_in  (win[j]),
        .hit_in   (hit[j]),
        .char_out (),
        .hit_out  (hit[j+1])
      );
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    match_nxt     = match_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    if (accept) begin
      if (in_end_req) begin
        pos_nxt       = '0;
        match_nxt     = '1;
        ovf_nxt       = 1'b0;
        out_valid_nxt = 1'b1;
      end else begin
        if (saturated) begin
          ovf_nxt = 1'b1;
        end else begin
          pos_nxt = pos_r + POS_W'(1);
        end
        if (hit[PAT_MAX]) begin
          match_nxt = MATCH_W'(start_pos);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_len_r   <= '0;
      pat_bytes_r <= '0;
      pos_r       <= '0;
      match_r     <= '1;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      match_r     <= match_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_LENGTH: pat_len_r   <= cfg_data[LEN_W-1:0];
          REG_PATTERN_BYTES:  pat_bytes_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_end_req) begin
      out_match_r <= match_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_index = out_match_r;
  assign out_overflow    = out_ovf_r;

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_end_req) |=> out_valid)
    else $error("end request did not produce a result");

  a_char_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    take_char |=> !out_valid)
    else $error("character request produced a result");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_end_req) |=> (pos_r == '0 && match_r == '1 && !ovf_r))
    else $error("string state not cleared after end request");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LIMIT)
    else $error("position ran past the limit");

  a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> saturated)
    else $error("overflow set without saturated position");

endmodule

// ===== bench/tb_rightmost_substring_match_core.sv =====
// Self-checking testbench for the rightmost substring match core.
`timescale 1ns / 1ps

module tb_rightmost_substring_match_core;
  import rsm_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_REQUESTS = 800;
  localparam int SETTLE_CYCLES   = 4;
  localparam int MAX_PRINTED     = 20;

  typedef struct packed {
    logic signed [MATCH_W-1:0] match_index;
    logic                      overflow;
  } match_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [CHAR_W-1:0]           in_character = '0;
  logic                        in_end_req = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [MATCH_W-1:0]   out_match_index;
  logic                        out_overflow;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [PBYTES_W-1:0]         cfg_data = '0;

  // Shadow of the core: current string and pattern registers.
  logic [CHAR_W-1:0]           window_chars [0:PAT_MAX-2];
  int unsigned                 string_pos;
  logic signed [MATCH_W-1:0]   rightmost_start;
  logic                        pos_saturated;
  logic [LEN_W-1:0]            pat_len = '0;
  logic [PBYTES_W-1:0]         pat_bytes = '0;

  match_result_t               pending_matches [$];
  int                          error_count = 0;
  int                          requests_sent = 0;
  int                          burst_left = 0;
  int                          idle_cycles = 0;
  int                          stall_mode = 0;
  int                          stall_left = 0;

  rightmost_substring_match_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_character    (in_character),
    .in_end_req      (in_end_req),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_index (out_match_index),
    .out_overflow    (out_overflow),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [CHAR_W-1:0] pattern_char(input int k);
    return pat_bytes[k*CHAR_W +: CHAR_W];
  endfunction

  function automatic int effective_len();
    return (pat_len > PAT_MAX) ? PAT_MAX : int'(pat_len);
  endfunction

  task automatic clear_string();
    int k;
    for (k = 0; k < PAT_MAX - 1; k++) window_chars[k] = '0;
    string_pos      = 0;
    rightmost_start = '1;
    pos_saturated   = 1'b0;
  endtask

  // Advance the shadow by one accepted request; queue the result of an end request.
  task automatic predict_match(input logic [CHAR_W-1:0] ch, input logic end_req);
    int unsigned   pos;
    int            len;
    int            k;
    logic          hit;
    match_result_t res;
    if (end_req) begin
      res.match_index = rightmost_start;
      res.overflow    = pos_saturated;
      pending_matches.push_back(res);
      clear_string();
    end else begin
      if (string_pos >= MAX_LEN) begin
        pos_saturated = 1'b1;
        pos = MAX_LEN - 1;
      end else begin
        pos = string_pos;
        string_pos++;
      end
      len = effective_len();
      if (len != 0 && pos + 1 >= len) begin
        hit = (ch == pattern_char(len - 1));
        for (k = 0; k + 1 < len; k++) begin
          if (window_chars[k] != pattern_char(len - 2 - k)) hit = 1'b0;
        end
        if (hit) rightmost_start = MATCH_W'(pos + 1 - len);
      end
      for (k = PAT_MAX - 2; k > 0; k--) window_chars[k] = window_chars[k-1];
      window_chars[0] = ch;
    end
  endtask

  task automatic report_mismatch(input string what, input int expected_v, input int actual_v);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("mismatch on %s: expected %0d, got %0d", what, expected_v, actual_v);
  endtask

  // Send one request; valid stays high on return so the next call can follow at once.
  task automatic send_item(input logic [CHAR_W-1:0] ch, input logic end_req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_character <= ch;
    in_end_req   <= end_req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    predict_match(ch, end_req);
  endtask

  // Drop valid and hold until every queued result has drained.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pattern(input logic [LEN_W-1:0] len, input logic [PBYTES_W-1:0] bytes);
    logic [CFG_IDX_W-1:0] idx [0:1];
    logic [PBYTES_W-1:0]  val [0:1];
    int                   i;
    idx[0] = REG_PATTERN_LENGTH;
    val[0] = {$urandom, 28'($urandom_range(0, 32'h0FFF_FFFF)), len};
    idx[1] = REG_PATTERN_BYTES;
    val[1] = bytes;
    wait_idle();
    for (i = 0; i < 2; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (idx[i] == REG_PATTERN_LENGTH) pat_len = val[i][LEN_W-1:0];
      else pat_bytes = val[i];
    end
    cfg_valid <= 1'b0;
  endtask

  // Mix of whole and partial pattern copies, pattern characters and noise.
  task automatic send_random_string(input int n_chars);
    int i;
    int k;
    int m;
    int pick;
    int len;
    len = effective_len();
    i = 0;
    while (i < n_chars) begin
      pick = $urandom_range(0, 9);
      if (len > 0 && pick < 3) begin
        m = ($urandom_range(0, 2) == 0) ? $urandom_range(1, len) : len;
        for (k = 0; k < m; k++) send_item(pattern_char(k), 1'b0);
        i += m;
      end else if (len > 0 && pick < 7) begin
        send_item(pattern_char(int'($urandom_range(0, len - 1))), 1'b0);
        i++;
      end else begin
        send_item(CHAR_W'($urandom_range(0, 255)), 1'b0);
        i++;
      end
    end
    send_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_reset_state();
    send_item(8'h41, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
  endtask

  task automatic test_directed_cases();
    int i;
    // single zero byte: an ordinary character that matches
    write_pattern(4'd1, '0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    // length above the maximum clamps; too few characters, then just enough
    write_pattern(4'd15, '1);
    for (i = 0; i < PAT_MAX - 1; i++) send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    for (i = 0; i < PAT_MAX; i++) send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_random_strings();
    int             start_count;
    int             phase;
    int             n_strings;
    int             s;
    int             k;
    logic [LEN_W-1:0]    len;
    logic [PBYTES_W-1:0] bytes;
    start_count = requests_sent;
    phase = 0;
    while (requests_sent - start_count < RANDOM_REQUESTS) begin
      case (phase)
        0: begin len = 4'd0;  bytes = {$urandom, $urandom}; end
        1: begin len = 4'd8;  bytes = '1; end
        2: begin len = 4'd15; bytes = {$urandom, $urandom}; end
        3: begin len = 4'd1;  bytes = '0; end
        default: begin
          len = ($urandom_range(0, 4) == 0) ? LEN_W'($urandom_range(0, 15))
                                            : LEN_W'($urandom_range(1, 8));
          if ($urandom_range(0, 2) == 0) begin
            bytes = {$urandom, $urandom};
          end else begin
            // narrow alphabet so that overlapping matches occur
            for (k = 0; k < PAT_MAX; k++)
              bytes[k*CHAR_W +: CHAR_W] = ($urandom_range(0, 7) == 0)
                                         ? CHAR_W'($urandom_range(0, 255))
                                         : CHAR_W'(8'h61 + $urandom_range(0, 1));
          end
        end
      endcase
      write_pattern(len, bytes);
      n_strings = $urandom_range(3, 8);
      for (s = 0; s < n_strings && requests_sent - start_count < RANDOM_REQUESTS; s++) begin
        send_random_string(($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                       : $urandom_range(0, 24));
        if ($urandom_range(0, 7) == 0) wait_idle();
      end
      phase++;
    end
  endtask

  // Receiver stall pattern: switch at random among always-ready, random and periodic modes.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 64);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      2:       out_ready <= $urandom_range(0, 1);
      3:       out_ready <= (stall_left[1:0] == 2'd0);
      default: out_ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin : check_results
    match_result_t head;
    if (rst_n && out_valid && out_ready) begin
      if (pending_matches.size() == 0) begin
        report_mismatch("unexpected result index", -2, int'(out_match_index));
      end else begin
        head = pending_matches.pop_front();
        if (out_match_index !== head.match_index)
          report_mismatch("match_index", int'(head.match_index), int'(out_match_index));
        if (out_overflow !== head.overflow)
          report_mismatch("overflow", int'(head.overflow), int'(out_overflow));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    clear_string();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed_cases();
    test_random_strings();
    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending_matches.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
